/* src/calrt_pkg.sv */
// Shared types, constants and calendar helper functions for the calendar
// clock with report timer. No dependencies; used by every module in src.
`timescale 1ns / 1ps
`default_nettype none

package calrt_pkg;

    // Request kinds carried in tuser
    typedef enum logic {
        REQ_TICK = 1'b0,
        REQ_SET  = 1'b1
    } t_req;

    // Configuration register indexes (byte address / 4)
    typedef enum logic {
        REG_MS_PER_SECOND   = 1'b0,
        REG_REPORT_INTERVAL = 1'b1
    } t_reg_idx;

    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned IN_TW   = 80;
    localparam int unsigned OUT_TW  = 112;

    // Register reset values
    localparam logic [15:0] MS_PER_SECOND_RST   = 16'd1000;
    localparam logic [15:0] REPORT_INTERVAL_RST = 16'd0;

    // Calendar reset values: 2022-01-01 00:00:00, a Saturday
    localparam logic [11:0] YEAR_RST    = 12'd2022;
    localparam logic [3:0]  MONTH_RST   = 4'd1;
    localparam logic [4:0]  DAY_RST     = 5'd1;
    localparam logic [2:0]  WEEKDAY_RST = 3'd6;
    localparam logic [31:0] STAMP_RST   = 32'd1640995200;

    // Roll-over limits
    localparam logic [11:0] YEAR_TOP    = 12'd2399;
    localparam logic [6:0]  SECOND_TOP  = 7'd59;
    localparam logic [6:0]  MINUTE_TOP  = 7'd59;
    localparam logic [5:0]  HOUR_TOP    = 6'd23;
    localparam logic [2:0]  WEEKDAY_TOP = 3'd6;
    localparam logic [3:0]  MONTH_DEC   = 4'd12;
    localparam logic [6:0]  SYNC_MARK   = 7'd30;

    // Month lengths in a common year, January first
    localparam logic [4:0] MONTH_DAYS [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Reciprocal of 100 scaled by 2^19; exact quotient for 12-bit years
    localparam logic [12:0] RECIP_100  = 13'd5243;
    localparam int unsigned RECIP_SHIFT = 19;

    typedef struct packed {
        logic [15:0] ms_per_second;
        logic [15:0] report_interval;
    } t_cfg;

    // Input beat fields, last field in the lowest bits
    typedef struct packed {
        logic [31:0] timestamp;
        logic [2:0]  weekday;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
    } t_set_beat;

    // Result beat fields, last field in the lowest bits
    typedef struct packed {
        logic        report_due;
        logic        sync_request;
        logic        second_tick;
        logic [31:0] hours_run;
        logic [31:0] epoch_seconds;
        logic [2:0]  weekday;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_result;

    // Gregorian leap test: quotient by 100 through the reciprocal
    function automatic logic is_leap(input logic [11:0] year);
        logic [24:0] prod;
        logic [5:0]  quot;
        logic [11:0] hundreds;
        logic [11:0] rem;
        prod     = {13'd0, year} * {12'd0, RECIP_100};
        quot     = prod[RECIP_SHIFT +: 6];
        hundreds = {6'd0, quot} * 12'd100;
        rem      = year - hundreds;
        return (year[1:0] == 2'd0) && ((rem != 12'd0) || (quot[1:0] == 2'd0));
    endfunction

    // Month length; a month code outside 1..12 counts as 31 days
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        if (month == 4'd0 || month > MONTH_DEC) begin
            len = 5'd31;
        end else begin
            len = MONTH_DAYS[month - 4'd1];
            if (month == 4'd2 && leap) begin
                len = len + 5'd1;
            end
        end
        return len;
    endfunction

endpackage

`default_nettype wire

/* src/calrt_regs.sv */
// APB configuration registers: ticks per second and report interval.
// Depends on calrt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module calrt_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [calrt_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output calrt_pkg::t_cfg                  o_cfg
);

    calrt_pkg::t_cfg  r_cfg;
    calrt_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = calrt_pkg::t_reg_idx'(paddr[2]);
    assign w_wr   = psel && penable && pwrite && pready;

    // Write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ms_per_second   <= calrt_pkg::MS_PER_SECOND_RST;
            r_cfg.report_interval <= calrt_pkg::REPORT_INTERVAL_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                calrt_pkg::REG_MS_PER_SECOND:   r_cfg.ms_per_second   <= pwdata[15:0];
                calrt_pkg::REG_REPORT_INTERVAL: r_cfg.report_interval <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (w_idx)
            calrt_pkg::REG_MS_PER_SECOND:   prdata = {16'd0, r_cfg.ms_per_second};
            calrt_pkg::REG_REPORT_INTERVAL: prdata = {16'd0, r_cfg.report_interval};
            default:                        prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* src/calrt_core.sv */
// Calendar state and its single-pass next-state logic: prescaler, cascaded
// second/minute/hour/day/month/year counters, report and run-hour counters.
// Depends on calrt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module calrt_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_go,
    input  wire logic                 i_is_set,
    input  wire calrt_pkg::t_set_beat i_set,
    input  wire calrt_pkg::t_cfg      i_cfg,
    output calrt_pkg::t_result        o_result
);

    logic [15:0] r_ms_count, n_ms_count;
    logic [5:0]  r_second,   n_second;
    logic [5:0]  r_minute,   n_minute;
    logic [4:0]  r_hour,     n_hour;
    logic [4:0]  r_day,      n_day;
    logic [3:0]  r_month,    n_month;
    logic [11:0] r_year,     n_year;
    logic [2:0]  r_weekday,  n_weekday;
    logic [31:0] r_stamp,    n_stamp;
    logic [15:0] r_msr,      n_msr;
    logic [31:0] r_hours,    n_hours;
    logic        r_leap,     n_leap;

    logic        w_tick, w_sync, w_report;
    logic [16:0] w_ms_next;
    logic [6:0]  w_sec_inc, w_min_inc;
    logic [5:0]  w_hour_inc, w_day_inc;
    logic [15:0] w_msr_inc;
    logic [4:0]  w_mlen;

    assign w_ms_next  = {1'b0, r_ms_count} + 17'd1;
    assign w_sec_inc  = {1'b0, r_second} + 7'd1;
    assign w_min_inc  = {1'b0, r_minute} + 7'd1;
    assign w_hour_inc = {1'b0, r_hour} + 6'd1;
    assign w_day_inc  = {1'b0, r_day} + 6'd1;
    assign w_msr_inc  = r_msr + 16'd1;
    assign w_mlen     = calrt_pkg::month_len(r_month, r_leap);

    // Next calendar state for the item in flight
    always_comb begin
        n_ms_count = r_ms_count;
        n_second   = r_second;
        n_minute   = r_minute;
        n_hour     = r_hour;
        n_day      = r_day;
        n_month    = r_month;
        n_year     = r_year;
        n_weekday  = r_weekday;
        n_stamp    = r_stamp;
        n_msr      = r_msr;
        n_hours    = r_hours;
        w_tick     = 1'b0;
        w_sync     = 1'b0;
        w_report   = 1'b0;
        if (i_go) begin
            if (i_is_set) begin
                n_year    = i_set.year;
                n_month   = i_set.month;
                n_day     = i_set.day;
                n_hour    = i_set.hour;
                n_minute  = i_set.minute;
                n_second  = i_set.second;
                n_weekday = i_set.weekday;
                n_stamp   = i_set.timestamp;
            end else if (w_ms_next >= {1'b0, i_cfg.ms_per_second}) begin
                n_ms_count = 16'd0;
                w_tick     = 1'b1;
                n_stamp    = r_stamp + 32'd1;
                w_sync     = ({1'b0, r_minute} == calrt_pkg::SYNC_MARK) &&
                             (w_sec_inc == calrt_pkg::SYNC_MARK);
                if (w_sec_inc > calrt_pkg::SECOND_TOP) begin
                    // Minute carry
                    n_second = 6'd0;
                    if (i_cfg.report_interval != 16'd0 &&
                        w_msr_inc >= i_cfg.report_interval) begin
                        n_msr    = 16'd0;
                        w_report = 1'b1;
                    end else begin
                        n_msr = w_msr_inc;
                    end
                    if (w_min_inc > calrt_pkg::MINUTE_TOP) begin
                        // Hour carry
                        n_minute = 6'd0;
                        n_hours  = r_hours + 32'd1;
                        if (w_hour_inc > calrt_pkg::HOUR_TOP) begin
                            // Day carry
                            n_hour    = 5'd0;
                            n_weekday = (r_weekday >= calrt_pkg::WEEKDAY_TOP) ?
                                        3'd0 : r_weekday + 3'd1;
                            if (w_day_inc > {1'b0, w_mlen}) begin
                                n_day = 5'd1;
                                if (r_month >= calrt_pkg::MONTH_DEC) begin
                                    n_month = 4'd1;
                                    if (r_year < calrt_pkg::YEAR_TOP) begin
                                        n_year = r_year + 12'd1;
                                    end
                                end else if (r_month == 4'd0) begin
                                    n_month = 4'd1;
                                end else begin
                                    n_month = r_month + 4'd1;
                                end
                            end else begin
                                n_day = w_day_inc[4:0];
                            end
                        end else begin
                            n_hour = w_hour_inc[4:0];
                        end
                    end else begin
                        n_minute = w_min_inc[5:0];
                    end
                end else begin
                    n_second = w_sec_inc[5:0];
                end
            end else begin
                n_ms_count = w_ms_next[15:0];
            end
        end
    end

    // Keep the leap flag in step with the year register
    assign n_leap = calrt_pkg::is_leap(n_year);

    // Hold the calendar state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms_count <= 16'd0;
            r_second   <= 6'd0;
            r_minute   <= 6'd0;
            r_hour     <= 5'd0;
            r_day      <= calrt_pkg::DAY_RST;
            r_month    <= calrt_pkg::MONTH_RST;
            r_year     <= calrt_pkg::YEAR_RST;
            r_weekday  <= calrt_pkg::WEEKDAY_RST;
            r_stamp    <= calrt_pkg::STAMP_RST;
            r_msr      <= 16'd0;
            r_hours    <= 32'd0;
            r_leap     <= 1'b0;
        end else begin
            r_ms_count <= n_ms_count;
            r_second   <= n_second;
            r_minute   <= n_minute;
            r_hour     <= n_hour;
            r_day      <= n_day;
            r_month    <= n_month;
            r_year     <= n_year;
            r_weekday  <= n_weekday;
            r_stamp    <= n_stamp;
            r_msr      <= n_msr;
            r_hours    <= n_hours;
            r_leap     <= n_leap;
        end
    end

    // Result of the item in flight
    always_comb begin
        o_result.second        = n_second;
        o_result.minute        = n_minute;
        o_result.hour          = n_hour;
        o_result.day           = n_day;
        o_result.month         = n_month;
        o_result.year          = n_year;
        o_result.weekday       = n_weekday;
        o_result.epoch_seconds = n_stamp;
        o_result.hours_run     = n_hours;
        o_result.second_tick   = w_tick;
        o_result.sync_request  = w_sync;
        o_result.report_due    = w_report;
    end

    // A completed second always clears the prescaler
    a_tick_clears_ms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tick |=> (r_ms_count == 16'd0))
        else $error("prescaler not cleared after a second");

    // A set item never advances the run-hour counter
    a_set_keeps_hours: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && i_is_set) |=> (r_hours == $past(r_hours)))
        else $error("run hours changed on a set item");

    // Leap flag follows the year register
    a_leap_tracks_year: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_leap == calrt_pkg::is_leap(r_year))
        else $error("leap flag out of step with year");

endmodule

`default_nettype wire

/* src/calendar_clock_with_report_timer_top.sv */
// Path: an accepted input beat goes through the input register, then the
// calendar update into the result register. Throughput: one beat per cycle
// unless m_axis_tready stalls, set by the single-pass calendar update.
// Reset: i_rst_n is synchronous, active low; it empties both stages and
// restores the calendar to 2022-01-01 00:00:00 Saturday and the registers.
`timescale 1ns / 1ps
`default_nettype none

module calendar_clock_with_report_timer_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Input stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: set_year[11:0], set_month[15:12], set_day[20:16], set_hour[25:21],
    // set_minute[31:26], set_second[37:32], set_weekday[40:38],
    // set_timestamp[72:41], zero fill[79:73]
    input  wire logic [calrt_pkg::IN_TW-1:0]   s_axis_tdata,
    // tuser: req_type[0]
    input  wire logic [0:0]                    s_axis_tuser,
    // Result stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // tdata: second_now[5:0], minute_now[11:6], hour_now[16:12], day_now[21:17],
    // month_now[25:22], year_now[37:26], weekday_now[40:38],
    // epoch_seconds[72:41], hours_run[104:73], second_tick[105],
    // sync_request[106], report_due[107], zero fill[111:108]
    output logic      [calrt_pkg::OUT_TW-1:0]  m_axis_tdata,
    // Configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [calrt_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);

    calrt_pkg::t_cfg      w_cfg;
    calrt_pkg::t_set_beat r_in_beat;
    calrt_pkg::t_req      r_in_req;
    logic                 r_in_valid;
    calrt_pkg::t_result   w_result;
    calrt_pkg::t_result   r_out;
    logic                 r_out_valid;
    logic                 w_go;
    logic                 w_in_take;

    calrt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Advance the held beat when the result register is free or drains
    assign w_go          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_go;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_beat <= s_axis_tdata[$bits(calrt_pkg::t_set_beat)-1:0];
            r_in_req  <= calrt_pkg::t_req'(s_axis_tuser[0]);
        end
    end

    calrt_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (w_go),
        .i_is_set (r_in_req == calrt_pkg::REQ_SET),
        .i_set    (r_in_beat),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(calrt_pkg::OUT_TW - $bits(calrt_pkg::t_result)){1'b0}}, r_out};

    // Flags only come with a completed second
    a_report_needs_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.report_due) |-> r_out.second_tick)
        else $error("report flag without a second tick");

    // Sync beat shows minute 30, second 30
    a_sync_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.sync_request) |->
        (r_out.second_tick && r_out.second == 6'd30 && r_out.minute == 6'd30))
        else $error("sync flag on the wrong time");

    // A beat in the input register moves on whenever the result side frees
    a_pipe_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |=> r_out_valid)
        else $error("held beat did not advance");

endmodule

`default_nettype wire
